@@ src/ngp_pkg.sv @@
package ngp_pkg;

  localparam int POS_FRAC_DIGITS_DEF = 6;

  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_Z     = 8'h7A;

  localparam logic [3:0] FLD_LAT  = 4'd2;
  localparam logic [3:0] FLD_NS   = 4'd3;
  localparam logic [3:0] FLD_LON  = 4'd4;
  localparam logic [3:0] FLD_EW   = 4'd5;
  localparam logic [3:0] FLD_FIX  = 4'd6;
  localparam logic [3:0] FLD_SATS = 4'd7;
  localparam logic [3:0] FLD_LAST = 4'd15;

  localparam logic [2:0]  NUM_FRAC_MAX = 3'd5;
  localparam logic [23:0] ACC_MAX      = 24'hFFFFFF;
  localparam logic [23:0] SATS_MAX     = 24'd32767;
  localparam logic [14:0] WHOLE_LIMIT  = 15'd18060;
  localparam logic [14:0] WHOLE_DEG    = 15'd100;
  localparam logic [30:0] POS_SAT      = 31'd1800000000;
  localparam logic [23:0] TEN_MILLION  = 24'd10000000;

  // Reciprocals: x/100 is ((x>>2)*DEG_RECIP)>>18 for x below 2^15, and
  // x/60 is ((x>>2)*DIV15_RECIP)>>32 for x below 2^30.
  localparam logic [13:0] DEG_RECIP   = 14'd10486;
  localparam logic [28:0] DIV15_RECIP = 29'd286331154;

  typedef struct packed {
    logic [23:0] acc;
    logic [2:0]  fd;
    logic        neg;
    logic        point;
    logic        illegal;
    logic        any;
  } num_st_t;

  typedef struct packed {
    logic              valid_res;
    logic [7:0]        ns;
    logic [7:0]        ew;
    logic signed [15:0] sats;
  } aux_t;

  typedef struct packed {
    logic        sat;
    logic [14:0] whole;
    logic [23:0] frac;
    logic [2:0]  fd;
  } pos_s1_t;

  typedef struct packed {
    logic        sat;
    logic [14:0] whole;
    logic [7:0]  deg;
    logic [23:0] fsc;
  } pos_s2_t;

  typedef struct packed {
    logic        sat;
    logic [6:0]  mins;
    logic [30:0] degp;
    logic [23:0] fsc;
  } pos_s3_t;

  typedef struct packed {
    logic        sat;
    logic [29:0] n;
    logic [30:0] degp;
  } pos_s4_t;

  typedef struct packed {
    logic        sat;
    logic [23:0] q;
    logic [30:0] degp;
  } pos_s5_t;

  typedef struct packed { aux_t aux; pos_s1_t lat; pos_s1_t lon; } stg1_t;
  typedef struct packed { aux_t aux; pos_s2_t lat; pos_s2_t lon; } stg2_t;
  typedef struct packed { aux_t aux; pos_s3_t lat; pos_s3_t lon; } stg3_t;
  typedef struct packed { aux_t aux; pos_s4_t lat; pos_s4_t lon; } stg4_t;
  typedef struct packed { aux_t aux; pos_s5_t lat; pos_s5_t lon; } stg5_t;

  typedef struct packed {
    logic               valid_res;
    logic [30:0]        latitude;
    logic [7:0]         north_south;
    logic [30:0]        longitude;
    logic [7:0]         east_west;
    logic signed [15:0] satellites;
  } res_t;

  function automatic longint unsigned pow10(int n);
    longint unsigned r;
    r = 1;
    for (int i = 0; i < n; i++) begin
      r = r * 10;
    end
    return r;
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  // Weight of the kept fraction in units of 1e-7 minute, by digit count.
  function automatic logic [23:0] frac_scale(logic [2:0] fd);
    logic [23:0] r;
    unique case (fd)
      3'd0:    r = 24'd10000000;
      3'd1:    r = 24'd1000000;
      3'd2:    r = 24'd100000;
      3'd3:    r = 24'd10000;
      3'd4:    r = 24'd1000;
      3'd5:    r = 24'd100;
      3'd6:    r = 24'd10;
      default: r = 24'd1;
    endcase
    return r;
  endfunction

  function automatic num_st_t num_char(num_st_t f, logic [7:0] c);
    num_st_t     r;
    logic [27:0] a;
    r = f;
    a = '0;
    if (!f.illegal) begin
      if (c == CH_MINUS && !f.any) begin
        r.neg = 1'b1;
      end else if (c == CH_DOT && !f.point) begin
        r.point = 1'b1;
      end else if (is_digit(c)) begin
        if (!f.point || f.fd < NUM_FRAC_MAX) begin
          a = 28'(f.acc) * 28'd10 + 28'(c[3:0]);
          r.acc = (a > 28'(ACC_MAX)) ? ACC_MAX : a[23:0];
          if (f.point) begin
            r.fd = f.fd + 3'd1;
          end
        end
      end else begin
        r.illegal = 1'b1;
      end
      r.any = 1'b1;
    end
    return r;
  endfunction

  function automatic pos_s2_t pos_stage2(pos_s1_t p);
    pos_s2_t     r;
    logic [26:0] pd;
    logic [47:0] pf;
    pd = 27'(p.whole[14:2]) * 27'(DEG_RECIP);
    pf = 48'(p.frac) * 48'(frac_scale(p.fd));
    r.sat   = p.sat;
    r.whole = p.whole;
    r.deg   = pd[25:18];
    r.fsc   = pf[23:0];
    return r;
  endfunction

  function automatic pos_s3_t pos_stage3(pos_s2_t p);
    pos_s3_t     r;
    logic [14:0] md;
    md = p.whole - 15'(p.deg) * WHOLE_DEG;
    r.sat  = p.sat;
    r.mins = md[6:0];
    r.degp = 31'(p.deg) * 31'(TEN_MILLION);
    r.fsc  = p.fsc;
    return r;
  endfunction

  function automatic pos_s4_t pos_stage4(pos_s3_t p);
    pos_s4_t r;
    r.sat  = p.sat;
    r.n    = 30'(p.mins) * 30'(TEN_MILLION) + 30'(p.fsc);
    r.degp = p.degp;
    return r;
  endfunction

  function automatic pos_s5_t pos_stage5(pos_s4_t p);
    pos_s5_t     r;
    logic [56:0] pq;
    pq = 57'(p.n[29:2]) * 57'(DIV15_RECIP);
    r.sat  = p.sat;
    r.q    = pq[55:32];
    r.degp = p.degp;
    return r;
  endfunction

  function automatic logic [30:0] pos_final(pos_s5_t p);
    return p.sat ? POS_SAT : p.degp + 31'(p.q);
  endfunction

endpackage

@@ src/ngp_char_if.sv @@
interface ngp_char_if;
  logic       valid;
  logic       ready;
  logic       start_req;
  logic [7:0] ch;

  modport source (output valid, output start_req, output ch, input ready);
  modport sink (input valid, input start_req, input ch, output ready);
endinterface

@@ src/ngp_res_if.sv @@
interface ngp_res_if;
  logic               valid;
  logic               ready;
  logic               valid_res;
  logic [30:0]        latitude;
  logic [7:0]         north_south;
  logic [30:0]        longitude;
  logic [7:0]         east_west;
  logic signed [15:0] satellites;

  modport source (output valid, output valid_res, output latitude, output north_south,
                  output longitude, output east_west, output satellites, input ready);
  modport sink (input valid, input valid_res, input latitude, input north_south,
                input longitude, input east_west, input satellites, output ready);
endinterface

@@ src/nmea_gga_field_parser.sv @@
// A terminator character's result passes through stages s1 to s5 and then the output register
// after its beat is accepted. Throughput: one character per cycle; a result waiting at the output
// stops input only once all six result stages, the output one included, are full.
// The parser state updates on each accepted character; the result path is six registered stages.
// Reset (asynchronous, active low) clears the parser as a start flag does and empties
// the result stages.
module nmea_gga_field_parser #(
  parameter int POS_FRAC_DIGITS = ngp_pkg::POS_FRAC_DIGITS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  ngp_char_if.sink      char_i,
  ngp_res_if.source     fix_o
);
  import ngp_pkg::*;

  localparam int FracW = $clog2(pow10(POS_FRAC_DIGITS));
  localparam int FdW   = $clog2(POS_FRAC_DIGITS + 1);

  typedef struct packed {
    logic [14:0]      whole;
    logic [FracW-1:0] frac;
    logic [FdW-1:0]   fd;
    logic             point;
  } pos_st_t;

  typedef struct packed {
    logic [3:0] idx;
    logic       fresh;
    logic       done;
    pos_st_t    lat;
    pos_st_t    lon;
    logic [7:0] ns;
    logic [7:0] ew;
    num_st_t    fix;
    num_st_t    cnt;
  } parse_st_t;

  function automatic parse_st_t st_init();
    parse_st_t r;
    r       = '0;
    r.fresh = 1'b1;
    return r;
  endfunction

  function automatic pos_st_t pos_char(pos_st_t p, logic [7:0] c);
    pos_st_t          r;
    logic [17:0]      w;
    logic [FracW+3:0] f;
    r = p;
    w = '0;
    f = '0;
    if (c == CH_DOT) begin
      r.point = 1'b1;
    end else if (is_digit(c)) begin
      if (!p.point) begin
        if (p.whole < WHOLE_LIMIT) begin
          w = 18'(p.whole) * 18'd10 + 18'(c[3:0]);
          r.whole = (w > 18'(WHOLE_LIMIT)) ? WHOLE_LIMIT : w[14:0];
        end
      end else if (p.fd < FdW'(POS_FRAC_DIGITS)) begin
        f = (FracW+4)'(p.frac) * (FracW+4)'(10) + (FracW+4)'(c[3:0]);
        r.frac = f[FracW-1:0];
        r.fd = p.fd + FdW'(1);
      end
    end
    return r;
  endfunction

  function automatic pos_s1_t pos_snap(pos_st_t p);
    pos_s1_t r;
    r.sat   = (p.whole == WHOLE_LIMIT);
    r.whole = p.whole;
    r.frac  = 24'(p.frac);
    r.fd    = 3'(p.fd);
    return r;
  endfunction

  parse_st_t   st_q, st_d, cur;
  logic        in_acc, is_term, launch, cnt_ill, fix_ok;
  logic [14:0] sat_mag;
  logic [15:0] sat_ext;
  stg1_t       s1_d, s1_q;
  stg2_t       s2_q;
  stg3_t       s3_q;
  stg4_t       s4_q;
  stg5_t       s5_q;
  logic [4:0]  v_q;
  logic [5:0]  rdy;
  res_t        out_d, out_q;
  logic        out_v_q;

  assign in_acc       = char_i.valid && rdy[0];
  assign char_i.ready = rdy[0];
  assign is_term      = (char_i.ch == CH_STAR) || (char_i.ch < CH_SPACE) ||
                        (char_i.ch > CH_Z);

  always_comb begin
    cur = st_q;
    if (char_i.start_req) begin
      cur = '0;
      cur.fresh = 1'b1;
    end
    st_d   = st_q;
    launch = 1'b0;
    if (in_acc) begin
      st_d = cur;
      if (!cur.done) begin
        st_d.fresh = 1'b0;
        if (cur.fresh && cur.idx == FLD_NS) begin
          st_d.ns = char_i.ch;
        end
        if (cur.fresh && cur.idx == FLD_EW) begin
          st_d.ew = char_i.ch;
        end
        if (is_term) begin
          st_d.done = 1'b1;
          launch = 1'b1;
        end else if (char_i.ch == CH_COMMA) begin
          if (cur.idx != FLD_LAST) begin
            st_d.idx = cur.idx + 4'd1;
          end
          st_d.fresh = 1'b1;
        end else begin
          unique case (cur.idx)
            FLD_LAT:  st_d.lat = pos_char(cur.lat, char_i.ch);
            FLD_LON:  st_d.lon = pos_char(cur.lon, char_i.ch);
            FLD_FIX:  st_d.fix = num_char(cur.fix, char_i.ch);
            FLD_SATS: st_d.cnt = num_char(cur.cnt, char_i.ch);
            default:  ;
          endcase
        end
      end
    end
  end

  // A count field cut short by any terminator other than the checksum mark is void.
  always_comb begin
    cnt_ill = st_d.cnt.illegal || (cur.idx == FLD_SATS && char_i.ch != CH_STAR);
    fix_ok  = (cur.idx >= FLD_SATS) && !st_d.fix.illegal && !st_d.fix.neg &&
              (st_d.fix.acc == 24'd1);
    sat_mag = (st_d.cnt.acc > SATS_MAX) ? SATS_MAX[14:0] : st_d.cnt.acc[14:0];
    sat_ext = {1'b0, sat_mag};
    s1_d.aux.valid_res = fix_ok;
    s1_d.aux.ns        = st_d.ns;
    s1_d.aux.ew        = st_d.ew;
    s1_d.aux.sats      = cnt_ill ? '0 :
                         (st_d.cnt.neg ? $signed(~sat_ext + 16'd1) : $signed(sat_ext));
    s1_d.lat           = pos_snap(st_d.lat);
    s1_d.lon           = pos_snap(st_d.lon);
  end

  always_comb begin
    rdy[5] = !out_v_q || fix_o.ready;
    for (int k = 4; k >= 0; k--) begin
      rdy[k] = !v_q[k] || rdy[k+1];
    end
  end

  always_comb begin
    out_d = '0;
    if (s5_q.aux.valid_res) begin
      out_d.valid_res   = 1'b1;
      out_d.latitude    = pos_final(s5_q.lat);
      out_d.north_south = s5_q.aux.ns;
      out_d.longitude   = pos_final(s5_q.lon);
      out_d.east_west   = s5_q.aux.ew;
      out_d.satellites  = s5_q.aux.sats;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= st_init();
      v_q     <= '0;
      out_v_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (rdy[0]) begin
        v_q[0] <= launch;
      end
      for (int k = 1; k < 5; k++) begin
        if (rdy[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
      if (rdy[5]) begin
        out_v_q <= v_q[4];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      s1_q <= s1_d;
    end
    if (rdy[1]) begin
      s2_q.aux <= s1_q.aux;
      s2_q.lat <= pos_stage2(s1_q.lat);
      s2_q.lon <= pos_stage2(s1_q.lon);
    end
    if (rdy[2]) begin
      s3_q.aux <= s2_q.aux;
      s3_q.lat <= pos_stage3(s2_q.lat);
      s3_q.lon <= pos_stage3(s2_q.lon);
    end
    if (rdy[3]) begin
      s4_q.aux <= s3_q.aux;
      s4_q.lat <= pos_stage4(s3_q.lat);
      s4_q.lon <= pos_stage4(s3_q.lon);
    end
    if (rdy[4]) begin
      s5_q.aux <= s4_q.aux;
      s5_q.lat <= pos_stage5(s4_q.lat);
      s5_q.lon <= pos_stage5(s4_q.lon);
    end
    if (rdy[5]) begin
      out_q <= out_d;
    end
  end

  assign fix_o.valid       = out_v_q;
  assign fix_o.valid_res   = out_q.valid_res;
  assign fix_o.latitude    = out_q.latitude;
  assign fix_o.north_south = out_q.north_south;
  assign fix_o.longitude   = out_q.longitude;
  assign fix_o.east_west   = out_q.east_west;
  assign fix_o.satellites  = out_q.satellites;

  a_term_sets_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    launch |=> st_q.done)
    else $error("terminator did not close the sentence");

  a_index_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && !char_i.start_req) |=> (st_q.idx >= $past(st_q.idx)))
    else $error("field index went backwards without a start flag");

  a_last_stage_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q[4] && !rdy[5]) |=> (v_q[4] && $stable(s5_q)))
    else $error("result stage lost a beat while the output was stalled");

  a_invalid_is_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fix_o.valid && !fix_o.valid_res) |-> (fix_o.latitude == '0 && fix_o.longitude == '0 &&
      fix_o.north_south == '0 && fix_o.east_west == '0 && fix_o.satellites == '0))
    else $error("result without a fix carries non-zero fields");

endmodule

@@ tb/tb_nmea_gga_field_parser.sv @@
module tb_nmea_gga_field_parser;
  timeunit 1ns;
  timeprecision 1ps;

  import ngp_pkg::*;

  localparam int         FRAC_DIGITS = POS_FRAC_DIGITS_DEF;
  localparam int         STALL_LIMIT = 5000;
  localparam int         COORD_LAT   = 0;
  localparam int         COORD_LON   = 1;
  localparam int         NUM_FIX     = 0;
  localparam int         NUM_SATS    = 1;
  localparam logic [7:0] CH_CR       = 8'h0D;
  localparam logic [7:0] CH_LF       = 8'h0A;

  logic clk = 1'b0;
  logic rst_n;

  ngp_char_if char_bus ();
  ngp_res_if  fix_bus ();

  nmea_gga_field_parser DUT (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .char_i (char_bus),
    .fix_o  (fix_bus)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  int          send_idle_pct;
  int          recv_idle_pct;
  int          fail_count;
  int          quiet_cycles;
  int unsigned live_chars;
  res_t        pending_fixes [$];
  logic [7:0]  sentence_q [$];

  logic [3:0]  fld;
  int unsigned crd_whole [2];
  int unsigned crd_frac [2];
  int unsigned crd_fd [2];
  bit          crd_point [2];
  int unsigned num_acc [2];
  int unsigned num_fd [2];
  bit          num_neg [2];
  bit          num_point [2];
  bit          num_bad [2];
  bit          num_any [2];
  logic [7:0]  hemi_ns;
  logic [7:0]  hemi_ew;
  bit          fresh;
  bit          done;

  function automatic void parser_clear();
    fld = '0;
    for (int k = 0; k < 2; k++) begin
      crd_whole[k] = 0;
      crd_frac[k]  = 0;
      crd_fd[k]    = 0;
      crd_point[k] = 1'b0;
      num_acc[k]   = 0;
      num_fd[k]    = 0;
      num_neg[k]   = 1'b0;
      num_point[k] = 1'b0;
      num_bad[k]   = 1'b0;
      num_any[k]   = 1'b0;
    end
    hemi_ns = '0;
    hemi_ew = '0;
    fresh   = 1'b1;
    done    = 1'b0;
  endfunction

  function automatic void coord_char(int k, logic [7:0] c);
    int unsigned d;
    int unsigned w;
    d = c - CH_ZERO;
    if (c == CH_DOT) begin
      crd_point[k] = 1'b1;
    end else if (c >= CH_ZERO && c <= CH_NINE) begin
      if (!crd_point[k]) begin
        if (crd_whole[k] < WHOLE_LIMIT) begin
          w = crd_whole[k] * 10 + d;
          crd_whole[k] = (w > WHOLE_LIMIT) ? WHOLE_LIMIT : w;
        end
      end else if (crd_fd[k] < FRAC_DIGITS) begin
        crd_frac[k] = crd_frac[k] * 10 + d;
        crd_fd[k]++;
      end
    end
  endfunction

  function automatic logic [30:0] coord_value(int k);
    longint unsigned scale;
    longint unsigned fs;
    longint unsigned mins;
    longint unsigned degs;
    if (crd_whole[k] > WHOLE_LIMIT - 1) begin
      return POS_SAT;
    end
    scale = 1;
    fs    = crd_frac[k];
    for (int i = 0; i < FRAC_DIGITS; i++) begin
      scale = scale * 10;
    end
    for (int i = crd_fd[k]; i < FRAC_DIGITS; i++) begin
      fs = fs * 10;
    end
    degs = crd_whole[k] / 100;
    mins = crd_whole[k] % 100;
    return 31'(degs * 64'd10000000 + ((mins * scale + fs) * 64'd10000000) / (64'd60 * scale));
  endfunction

  function automatic void number_char(int k, logic [7:0] c);
    int unsigned a;
    if (num_bad[k]) begin
      return;
    end
    if (c == CH_MINUS && !num_any[k]) begin
      num_neg[k] = 1'b1;
    end else if (c == CH_DOT && !num_point[k]) begin
      num_point[k] = 1'b1;
    end else if (c >= CH_ZERO && c <= CH_NINE) begin
      if (!num_point[k] || num_fd[k] < NUM_FRAC_MAX) begin
        a = num_acc[k] * 10 + (c - CH_ZERO);
        num_acc[k] = (a > ACC_MAX) ? ACC_MAX : a;
        if (num_point[k]) begin
          num_fd[k]++;
        end
      end
    end else begin
      num_bad[k] = 1'b1;
    end
    num_any[k] = 1'b1;
  endfunction

  function automatic bit gga_predict(logic start, logic [7:0] c, output res_t fix);
    bit          first;
    bit          term;
    int unsigned m;
    fix = '0;
    if (start) begin
      parser_clear();
    end
    if (done) begin
      return 1'b0;
    end
    live_chars++;
    first = fresh;
    fresh = 1'b0;
    if (first && fld == FLD_NS) begin
      hemi_ns = c;
    end
    if (first && fld == FLD_EW) begin
      hemi_ew = c;
    end
    term = (c == CH_STAR) || (c < CH_SPACE) || (c > CH_Z);
    if (!term) begin
      if (c == CH_COMMA) begin
        if (fld < FLD_LAST) begin
          fld++;
        end
        fresh = 1'b1;
      end else if (fld == FLD_LAT) begin
        coord_char(COORD_LAT, c);
      end else if (fld == FLD_LON) begin
        coord_char(COORD_LON, c);
      end else if (fld == FLD_FIX) begin
        number_char(NUM_FIX, c);
      end else if (fld == FLD_SATS) begin
        number_char(NUM_SATS, c);
      end
      return 1'b0;
    end
    if (fld == FLD_SATS && c != CH_STAR) begin
      num_bad[NUM_SATS] = 1'b1;
    end
    done = 1'b1;
    if (fld >= FLD_SATS && !num_bad[NUM_FIX] && !num_neg[NUM_FIX] && num_acc[NUM_FIX] == 1) begin
      fix.valid_res   = 1'b1;
      fix.latitude    = coord_value(COORD_LAT);
      fix.north_south = hemi_ns;
      fix.longitude   = coord_value(COORD_LON);
      fix.east_west   = hemi_ew;
      if (!num_bad[NUM_SATS]) begin
        m = (num_acc[NUM_SATS] > SATS_MAX) ? SATS_MAX : num_acc[NUM_SATS];
        fix.satellites = 16'(m);
        if (num_neg[NUM_SATS]) begin
          fix.satellites = -fix.satellites;
        end
      end
    end
    return 1'b1;
  endfunction

  function automatic void report_failure(string msg);
    if (fail_count < 10) begin
      $display("%s", msg);
    end
    fail_count++;
  endfunction

  function automatic void check_field(string name, longint want, longint got);
    if (want != got) begin
      report_failure($sformatf("%s: expected %0d, got %0d", name, want, got));
    end
  endfunction

  always @(posedge clk) begin : fix_checker
    res_t want;
    fix_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
    if (fix_bus.valid && fix_bus.ready) begin
      if (pending_fixes.size() == 0) begin
        report_failure($sformatf("result beat with nothing expected: valid_res %0d lat %0d lon %0d",
                                 fix_bus.valid_res, fix_bus.latitude, fix_bus.longitude));
      end else begin
        want = pending_fixes.pop_front();
        check_field("valid_res", want.valid_res, fix_bus.valid_res);
        check_field("latitude", want.latitude, fix_bus.latitude);
        check_field("north_south", want.north_south, fix_bus.north_south);
        check_field("longitude", want.longitude, fix_bus.longitude);
        check_field("east_west", want.east_west, fix_bus.east_west);
        check_field("satellites", longint'($signed(want.satellites)),
                    longint'($signed(fix_bus.satellites)));
      end
    end
  end

  always @(posedge clk) begin
    if ((char_bus.valid && char_bus.ready) || (fix_bus.valid && fix_bus.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Holds the beat until the parser takes it, then updates the expected results.
  task automatic send_char(logic start, logic [7:0] c);
    res_t fix;
    while ($urandom_range(99) < send_idle_pct) begin
      char_bus.valid <= 1'b0;
      @(posedge clk);
    end
    char_bus.valid     <= 1'b1;
    char_bus.start_req <= start;
    char_bus.ch        <= c;
    do begin
      @(posedge clk);
    end while (!char_bus.ready);
    if (gga_predict(start, c, fix)) begin
      pending_fixes.push_back(fix);
    end
  endtask

  task automatic send_sentence(bit with_start);
    for (int i = 0; i < sentence_q.size(); i++) begin
      send_char(with_start && i == 0, sentence_q[i]);
    end
    sentence_q.delete();
  endtask

  task automatic wait_drained();
    char_bus.valid <= 1'b0;
    do begin
      @(posedge clk);
    end while (pending_fixes.size() != 0);
  endtask

  function automatic void add_text(string s);
    for (int i = 0; i < s.len(); i++) begin
      sentence_q.push_back(s[i]);
    end
  endfunction

  function automatic void add_crlf();
    sentence_q.push_back(CH_CR);
    sentence_q.push_back(CH_LF);
  endfunction

  function automatic void add_digits(int n);
    for (int i = 0; i < n; i++) begin
      sentence_q.push_back(8'(CH_ZERO + $urandom_range(9)));
    end
  endfunction

  function automatic logic [7:0] odd_char();
    logic [7:0] c;
    do begin
      c = 8'($urandom_range(CH_SPACE, CH_Z));
    end while (c == CH_COMMA || c == CH_STAR);
    return c;
  endfunction

  function automatic void add_coord();
    case ($urandom_range(9))
      7: begin
        add_digits($urandom_range(0, 7));
      end
      8: begin
        add_text($urandom_range(1) ? "1805" : "1806");
        add_digits(1);
        sentence_q.push_back(CH_DOT);
        add_digits($urandom_range(0, 8));
      end
      9: begin
        repeat ($urandom_range(1, 8)) begin
          if ($urandom_range(1)) begin
            sentence_q.push_back(odd_char());
          end else begin
            add_digits(1);
          end
        end
      end
      default: begin
        add_digits($urandom_range(4, 5));
        sentence_q.push_back(CH_DOT);
        add_digits($urandom_range(0, 8));
      end
    endcase
  endfunction

  function automatic void add_hemisphere(string pair);
    case ($urandom_range(7))
      0: begin
      end
      1: begin
        sentence_q.push_back(odd_char());
      end
      2: begin
        sentence_q.push_back(odd_char());
        sentence_q.push_back(odd_char());
      end
      default: begin
        sentence_q.push_back(pair[$urandom_range(1)]);
      end
    endcase
  endfunction

  function automatic void add_number();
    if ($urandom_range(3) == 0) begin
      sentence_q.push_back(CH_MINUS);
    end
    add_digits($urandom_range(0, 8));
    if ($urandom_range(1)) begin
      sentence_q.push_back(CH_DOT);
      add_digits($urandom_range(0, 7));
    end
    if ($urandom_range(7) == 0) begin
      case ($urandom_range(2))
        0:       sentence_q.push_back(CH_MINUS);
        1:       sentence_q.push_back(CH_DOT);
        default: sentence_q.push_back(odd_char());
      endcase
      add_digits($urandom_range(0, 2));
    end
  endfunction

  task automatic test_positions();
    add_text("$GPGGA,123519,4807.038,N,01131.000,E,1,08,0.9,545.4,M,46.9,M,,*47");
    add_crlf();
    send_sentence(1'b0);
    add_text("$GPGGA,0,18059.9999999,S,18060,W,1,12*");
    send_sentence(1'b1);
    add_text("$GPGGA,,00000,z,9x9.-5.5 ,E,1,3*");
    send_sentence(1'b1);
    add_text("$GPGGA,,,,123456789,,1,0*");
    send_sentence(1'b1);
  endtask

  task automatic test_number_rules();
    add_text("$GPGGA,,1,N,1,E,01,-40000*");
    send_sentence(1'b1);
    add_text("$GPGGA,,1,N,1,E,.1,99999999*");
    send_sentence(1'b1);
    add_text("$GPGGA,,1,N,1,E,-1,5*");
    send_sentence(1'b1);
    add_text("$GPGGA,,1,N,1,E,1.0,5*");
    send_sentence(1'b1);
    add_text("$GPGGA,,1,N,1,E,1a,5*");
    send_sentence(1'b1);
    add_text("$GPGGA,,1,N,1,E,1,3.141592*");
    send_sentence(1'b1);
    add_text("$GPGGA,,1,N,1,E,1.,--1*");
    send_sentence(1'b1);
    add_text("$GPGGA,,1,N,1,E,1,-*");
    send_sentence(1'b1);
    add_text("$GPGGA,,1,N,1,E,1,1.-*");
    send_sentence(1'b1);
  endtask

  task automatic test_terminators();
    add_text("$GPGGA,,4807,N,01131,E,1,08");
    add_crlf();
    send_sentence(1'b1);
    add_text("$GPGGA,,48");
    sentence_q.push_back(8'hFF);
    send_sentence(1'b1);
    add_text("$GPGGA,,1,N,1,E,1,9,x");
    sentence_q.push_back(8'h00);
    send_sentence(1'b1);
    add_text("$GPGGA,,1,N,1,E,1,7,");
    sentence_q.push_back(CH_Z + 8'd1);
    send_sentence(1'b1);
    add_text("$GPGGA,,1,N,1,E,1,4,,,,,,,,,,*");
    send_sentence(1'b1);
    // Nothing after a terminator counts until the next start flag.
    add_text("$GPGGA,,1,N,1,E,1,6*");
    send_sentence(1'b0);
    add_text("$GPGGA,,12");
    send_sentence(1'b1);
    add_text("$GPGGA,,34,S,56,W,1,2*");
    send_sentence(1'b1);
    add_text("$GPGGA,,1,*");
    send_sentence(1'b1);
    add_text("$GP");
    sentence_q.push_back(CH_SPACE - 8'd1);
    send_sentence(1'b1);
  endtask

  task automatic test_random_sentences(int unsigned char_goal);
    int unsigned chars0;
    bit          with_start;
    chars0 = live_chars;
    while (live_chars - chars0 < char_goal) begin
      with_start = ($urandom_range(19) != 0);
      add_text("$GPGGA,");
      add_digits(6);
      sentence_q.push_back(CH_COMMA);
      add_coord();
      sentence_q.push_back(CH_COMMA);
      add_hemisphere("NS");
      sentence_q.push_back(CH_COMMA);
      add_coord();
      sentence_q.push_back(CH_COMMA);
      add_hemisphere("EW");
      sentence_q.push_back(CH_COMMA);
      case ($urandom_range(9))
        0, 1:    add_number();
        2:       add_digits($urandom_range(1, 2));
        default: add_text("1");
      endcase
      sentence_q.push_back(CH_COMMA);
      if ($urandom_range(4) == 0) begin
        add_number();
      end else begin
        add_digits($urandom_range(0, 2));
      end
      case ($urandom_range(3))
        0: begin
        end
        1: begin
          add_text(",0.9,545.4,M,46.9,M,,");
        end
        default: begin
          repeat ($urandom_range(1, 12)) begin
            sentence_q.push_back(CH_COMMA);
            add_digits($urandom_range(0, 2));
          end
        end
      endcase
      if ($urandom_range(11) == 0) begin
        repeat ($urandom_range(sentence_q.size() - 1)) begin
          void'(sentence_q.pop_back());
        end
      end else begin
        case ($urandom_range(9))
          7: begin
            add_crlf();
          end
          8: begin
            sentence_q.push_back(8'($urandom_range(CH_Z + 1, 8'hFF)));
          end
          9: begin
            sentence_q.push_back(8'($urandom_range(0, CH_SPACE - 1)));
          end
          default: begin
            sentence_q.push_back(CH_STAR);
            add_digits(2);
            add_crlf();
          end
        endcase
      end
      send_sentence(with_start);
      if ($urandom_range(15) == 0) begin
        wait_drained();
      end
    end
  endtask

  initial begin
    rst_n              = 1'b0;
    char_bus.valid     = 1'b0;
    char_bus.start_req = 1'b0;
    char_bus.ch        = '0;
    fix_bus.ready      = 1'b0;
    fail_count         = 0;
    quiet_cycles       = 0;
    live_chars         = 0;
    send_idle_pct      = 26;
    recv_idle_pct      = 58;
    parser_clear();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    test_positions();
    test_number_rules();
    test_terminators();
    wait_drained();

    test_random_sentences(400);
    send_idle_pct = 58;
    recv_idle_pct = 26;
    test_random_sentences(400);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_sentences(400);

    wait_drained();
    repeat (12) @(posedge clk);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
